// ----- src/pts_pkg.sv -----
// Package for the priority task scheduler: sizes, slot status codes, command codes
// and the structs shared by the slot cells and the top level. No dependencies.

package pts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [7:0] IDLE_PRIO = 8'd255;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_DELAY  = 2'd1,
    FUNC_CREATE = 2'd2,
    FUNC_SET    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    SLOT_READY   = 2'd0,
    SLOT_RUNNING = 2'd1,
    SLOT_BLOCKED = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_COMMIT
  } ctrl_st_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] amount;
    logic [7:0]  prio;
  } in_t;

  typedef struct packed {
    logic [2:0]  running_task;
    logic [31:0] tick_now;
    logic        create_ok;
    logic [2:0]  new_slot;
    logic        switched;
  } out_t;

  // Per-cell update commands from the controller.
  typedef struct packed {
    logic do_wake;
    logic do_block;
    logic to_ready;
    logic to_running;
    logic do_create;
  } cell_cmd_t;

  // Data broadcast to every cell.
  typedef struct packed {
    logic [31:0] tick;
    logic [31:0] wake_val;
    logic [7:0]  prio;
  } bcast_t;

  // Running result handed from cell to cell during a scan.
  typedef struct packed {
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              cand_found;
    logic [7:0]        best_prio;
    logic [SLOT_W-1:0] best_idx;
  } token_t;

  // Slot index reduced or extended to the three-bit result fields.
  function automatic logic [2:0] to_out3(input logic [SLOT_W-1:0] v);
    logic [SLOT_W+2:0] ext;
    ext = (SLOT_W + 3)'(v);
    return ext[2:0];
  endfunction

endpackage

// ----- src/priority_task_scheduler_with_delays.sv -----
// Top level of the priority task scheduler: controller, tick counter and the
// row of slot cells. Depends on pts_pkg and pts_cell.

// Fixed-priority task scheduler over a table of pts_pkg::MAX_TASKS slots, each
// held in its own cell. A command is transferred at a rising edge with start
// high and busy low; its one result is transferred on out_valid, high for a
// single cycle, and the receiver cannot stall it, so it must take every
// result as it appears. Task selection and free-slot search run as a token
// that passes down the row of cells, one slot per cycle. A tick or a delay
// therefore holds busy through an update state, the scan and a commit
// state, and no further command is taken until its result appears. A
// creation skips the update state. A write of the tick counter is answered
// in the next cycle and leaves busy low, so such commands may arrive in
// every cycle. The result always appears in a cycle with busy low.

module priority_task_scheduler_with_delays (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pts_pkg::in_t   in_data,
  output logic           out_valid,
  output pts_pkg::out_t  out_data
);

  localparam int N = pts_pkg::MAX_TASKS;
  localparam int W = pts_pkg::SLOT_W;

  pts_pkg::ctrl_st_t st_r, st_nxt;
  pts_pkg::in_t      cmd_r, cmd_nxt;
  logic [31:0]       tick_r, tick_nxt;
  logic [W-1:0]      run_r, run_nxt;
  logic [W-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  pts_pkg::out_t     out_r, out_nxt;

  pts_pkg::cell_cmd_t cell_cmd [N];
  pts_pkg::token_t    tok_in   [N];
  pts_pkg::token_t    tok_out  [N];
  pts_pkg::bcast_t    bcast;

  logic              accept;
  logic [W-1:0]      best;
  logic              sw;
  pts_pkg::token_t   final_tok;

  assign accept    = start && !busy;
  assign busy      = (st_r != pts_pkg::ST_IDLE);
  assign final_tok = tok_out[N-1];
  assign best      = final_tok.cand_found ? final_tok.best_idx : '0;
  assign sw        = (best != run_r);

  // The delay target is computed once here and broadcast; only the running
  // cell takes it.
  always_comb begin
    bcast.tick     = tick_r;
    bcast.wake_val = tick_r + cmd_r.amount;
    bcast.prio     = cmd_r.prio;
  end

  // Controller: next state, counter updates, per-cell commands and result.
  always_comb begin
    st_nxt        = st_r;
    cmd_nxt       = cmd_r;
    tick_nxt      = tick_r;
    run_nxt       = run_r;
    scan_cnt_nxt  = scan_cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    for (int i = 0; i < N; i++) begin
      cell_cmd[i] = '0;
    end

    unique case (st_r)
      pts_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_data;
          unique case (in_data.func) inside
            pts_pkg::FUNC_TICK, pts_pkg::FUNC_DELAY: begin
              st_nxt = pts_pkg::ST_APPLY;
            end
            pts_pkg::FUNC_CREATE: begin
              st_nxt       = pts_pkg::ST_SCAN;
              scan_cnt_nxt = '0;
            end
            pts_pkg::FUNC_SET: begin
              // Counter write: no selection follows, so the answer is set up here.
              tick_nxt              = in_data.amount;
              out_valid_nxt         = 1'b1;
              out_nxt.running_task  = pts_pkg::to_out3(run_r);
              out_nxt.tick_now      = in_data.amount;
              out_nxt.create_ok     = 1'b0;
              out_nxt.new_slot      = 3'd0;
              out_nxt.switched      = 1'b0;
            end
            default: begin
              st_nxt = pts_pkg::ST_IDLE;
            end
          endcase
        end
      end

      pts_pkg::ST_APPLY: begin
        if (cmd_r.func == pts_pkg::FUNC_TICK) begin
          // Wake against the old counter value, then advance it.
          for (int i = 0; i < N; i++) begin
            cell_cmd[i].do_wake = 1'b1;
          end
          tick_nxt = tick_r + 32'd1;
        end else begin
          for (int i = 0; i < N; i++) begin
            cell_cmd[i].do_block = (run_r == W'(i));
          end
        end
        st_nxt       = pts_pkg::ST_SCAN;
        scan_cnt_nxt = '0;
      end

      pts_pkg::ST_SCAN: begin
        // Count the slots the token has passed; move on to the commit at the last one.
        scan_cnt_nxt = scan_cnt_r + W'(1);
        if (scan_cnt_r == W'(N - 1)) begin
          st_nxt = pts_pkg::ST_COMMIT;
        end
      end

      pts_pkg::ST_COMMIT: begin
        out_valid_nxt     = 1'b1;
        out_nxt.tick_now  = tick_r;
        out_nxt.create_ok = 1'b0;
        out_nxt.new_slot  = 3'd0;
        out_nxt.switched  = 1'b0;
        if (cmd_r.func == pts_pkg::FUNC_CREATE) begin
          if (final_tok.free_found) begin
            for (int i = 0; i < N; i++) begin
              cell_cmd[i].do_create = (final_tok.free_idx == W'(i));
            end
            out_nxt.create_ok = 1'b1;
            out_nxt.new_slot  = pts_pkg::to_out3(final_tok.free_idx);
          end
        end else if (sw) begin
          // The old task steps down unless it has just blocked itself.
          for (int i = 0; i < N; i++) begin
            cell_cmd[i].to_ready   = (run_r == W'(i));
            cell_cmd[i].to_running = (best == W'(i));
          end
          run_nxt          = best;
          out_nxt.switched = 1'b1;
        end
        out_nxt.running_task = pts_pkg::to_out3(run_nxt);
        st_nxt               = pts_pkg::ST_IDLE;
      end

      default: begin
        st_nxt = pts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= pts_pkg::ST_IDLE;
      tick_r      <= '0;
      run_r       <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      tick_r      <= tick_nxt;
      run_r       <= run_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The row of slot cells; the token enters empty at slot 0.
  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign tok_in[g] = '0;
    end else begin : g_link
      assign tok_in[g] = tok_out[g-1];
    end

    pts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .slot_idx (W'(g)),
      .cmd      (cell_cmd[g]),
      .bcast    (bcast),
      .tok_in   (tok_in[g]),
      .tok_out  (tok_out[g])
    );
  end

  // A result is only ever shown while the block is free for the next command.
  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Every result comes from a commit or from a counter write.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(st_r) == pts_pkg::ST_COMMIT) ||
                  ($past(accept) && $past(in_data.func) == pts_pkg::FUNC_SET))
    else $error("result strobe without a source");

  // A counter write is answered in the very next cycle.
  a_set_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.func == pts_pkg::FUNC_SET) |=> out_valid)
    else $error("counter write not answered");

  // The running slot only moves at a commit.
  a_run_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != pts_pkg::ST_COMMIT) |=> $stable(run_r))
    else $error("running slot moved outside a commit");

endmodule

// ----- src/pts_cell.sv -----
// One slot of the task table: in-use bit, status, priority and wake tick,
// plus one stage of the selection token chain. Depends on pts_pkg.

module pts_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [pts_pkg::SLOT_W-1:0] slot_idx,
  input  pts_pkg::cell_cmd_t        cmd,
  input  pts_pkg::bcast_t           bcast,
  input  pts_pkg::token_t           tok_in,
  output pts_pkg::token_t           tok_out
);

  logic              used_r, used_nxt;
  pts_pkg::slot_st_t st_r, st_nxt;
  logic [7:0]        prio_r, prio_nxt;
  logic [31:0]       wake_r, wake_nxt;
  pts_pkg::token_t   tok_r, tok_nxt;
  logic              is_idle_slot;

  assign is_idle_slot = (slot_idx == '0);

  always_comb begin
    used_nxt = used_r;
    st_nxt   = st_r;
    prio_nxt = prio_r;
    wake_nxt = wake_r;
    if (cmd.do_wake && used_r && st_r == pts_pkg::SLOT_BLOCKED && wake_r <= bcast.tick) begin
      st_nxt = pts_pkg::SLOT_READY;
    end
    if (cmd.do_block) begin
      st_nxt   = pts_pkg::SLOT_BLOCKED;
      wake_nxt = bcast.wake_val;
    end
    if (cmd.to_ready && st_r != pts_pkg::SLOT_BLOCKED) begin
      st_nxt = pts_pkg::SLOT_READY;
    end
    if (cmd.to_running) begin
      st_nxt = pts_pkg::SLOT_RUNNING;
    end
    if (cmd.do_create) begin
      used_nxt = 1'b1;
      st_nxt   = pts_pkg::SLOT_READY;
      prio_nxt = bcast.prio;
    end
  end

  // Fold this slot into the token: first free slot, best runnable candidate.
  always_comb begin
    tok_nxt = tok_in;
    if (!used_r && !tok_in.free_found) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_idx   = slot_idx;
    end
    if (used_r && (st_r == pts_pkg::SLOT_READY || st_r == pts_pkg::SLOT_RUNNING) &&
        (!tok_in.cand_found || prio_r < tok_in.best_prio)) begin
      tok_nxt.cand_found = 1'b1;
      tok_nxt.best_prio  = prio_r;
      tok_nxt.best_idx   = slot_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= is_idle_slot;
      st_r   <= is_idle_slot ? pts_pkg::SLOT_RUNNING : pts_pkg::SLOT_BLOCKED;
      prio_r <= is_idle_slot ? pts_pkg::IDLE_PRIO : 8'd0;
      wake_r <= '0;
    end else begin
      used_r <= used_nxt;
      st_r   <= st_nxt;
      prio_r <= prio_nxt;
      wake_r <= wake_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_out = tok_r;

endmodule
